>>> rtl/swaabb_pkg.sv
`default_nettype none
package swaabb_pkg;

   localparam int COORD_WIDTH    = 24;
   localparam int TIME_FRAC_BITS = 16;

   // derived widths
   localparam int SIZE_WIDTH = COORD_WIDTH - 1;
   localparam int DIST_WIDTH = COORD_WIDTH + 2;      // signed entry/exit distance
   localparam int VEL_WIDTH  = COORD_WIDTH + 1;      // signed relative velocity
   localparam int MAG_WIDTH  = COORD_WIDTH + 1;      // divider operand magnitude
   localparam int REM_WIDTH  = COORD_WIDTH + 2;      // divider partial remainder
   localparam int QUO_WIDTH  = TIME_FRAC_BITS + 1;   // quotient bits kept
   localparam int TIME_WIDTH = TIME_FRAC_BITS + 2;   // clamped signed time
   localparam int ETIME_WIDTH = TIME_FRAC_BITS + 1;  // output entry time

   // divider pipeline
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = (QUO_WIDTH + DIV_STEPS - 1) / DIV_STEPS;

   // clamped time range: -1 stands for any negative, TIME_HI for anything past one
   localparam logic signed [TIME_WIDTH-1:0] TIME_ONE = TIME_WIDTH'(1) << TIME_FRAC_BITS;
   localparam logic signed [TIME_WIDTH-1:0] TIME_HI  = TIME_ONE + TIME_WIDTH'(1);
   localparam logic signed [TIME_WIDTH-1:0] TIME_LO  = '1;

   typedef enum logic [1:0] {
      SIDE_UP    = 2'd0,
      SIDE_RIGHT = 2'd1,
      SIDE_DOWN  = 2'd2,
      SIDE_LEFT  = 2'd3
   } side_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] first_x;
      logic signed [COORD_WIDTH-1:0] first_y;
      logic        [SIZE_WIDTH-1:0]  first_w;
      logic        [SIZE_WIDTH-1:0]  first_h;
      logic signed [COORD_WIDTH-1:0] first_vx;
      logic signed [COORD_WIDTH-1:0] first_vy;
      logic signed [COORD_WIDTH-1:0] second_x;
      logic signed [COORD_WIDTH-1:0] second_y;
      logic        [SIZE_WIDTH-1:0]  second_w;
      logic        [SIZE_WIDTH-1:0]  second_h;
      logic signed [COORD_WIDTH-1:0] second_vx;
      logic signed [COORD_WIDTH-1:0] second_vy;
   } req_type;

   typedef struct packed {
      logic                   hit;
      logic [ETIME_WIDTH-1:0] entry_time;
      logic [1:0]             hit_side;
   } rsp_type;

   // per-axis flags that ride alongside the dividers
   typedef struct packed {
      logic v_zero;
      logic de_pos;
      logic dx_pos;
      logic ent_neg;
      logic ex_neg;
   } axis_meta_type;

   typedef struct packed {
      logic          valid;
      axis_meta_type ax;
      axis_meta_type ay;
   } meta_type;

   // floor quotient clamped to [-1, TIME_HI]
   function automatic logic signed [TIME_WIDTH-1:0] clamp_time(
      input logic                 neg,
      input logic                 ovf,
      input logic [QUO_WIDTH-1:0] q,
      input logic                 rem_nz
   );
      logic signed [TIME_WIDTH-1:0] res;
      if (neg) begin
         res = (ovf || (q != '0) || rem_nz) ? TIME_LO : '0;
      end else if (ovf || (TIME_WIDTH'(q) > TIME_HI)) begin
         res = TIME_HI;
      end else begin
         res = signed'(TIME_WIDTH'(q));
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> rtl/swaabb_div.sv
`default_nettype none
module swaabb_div (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic [swaabb_pkg::MAG_WIDTH-1:0] num,
   input  wire logic [swaabb_pkg::MAG_WIDTH-1:0] den,
   output logic      [swaabb_pkg::QUO_WIDTH-1:0] quo,
   output logic                                  rem_nz,
   output logic                                  ovf
);
   import swaabb_pkg::*;

   // restoring long division, DIV_STEPS quotient bits per stage
   logic [REM_WIDTH-1:0] rem_ff [DIV_STAGES];
   logic [MAG_WIDTH-1:0] den_ff [DIV_STAGES];
   logic [QUO_WIDTH-1:0] quo_ff [DIV_STAGES];
   logic                 ovf_ff [DIV_STAGES];

   logic [REM_WIDTH-1:0] rem_in [DIV_STAGES];
   logic [QUO_WIDTH-1:0] quo_in [DIV_STAGES];

   // what each stage starts from
   logic [REM_WIDTH-1:0] rem_src [DIV_STAGES];
   logic [QUO_WIDTH-1:0] quo_src [DIV_STAGES];
   logic [MAG_WIDTH-1:0] den_src [DIV_STAGES];
   logic                 ovf_src [DIV_STAGES];

   genvar s;
   generate
      for (s = 0; s < DIV_STAGES; s++) begin : g_stage
         if (s == 0) begin : g_first
            assign rem_src[s] = REM_WIDTH'(num);
            assign quo_src[s] = '0;
            assign den_src[s] = den;
            assign ovf_src[s] = {1'b0, num} >= {den, 1'b0};
         end else begin : g_next
            assign rem_src[s] = rem_ff[s-1];
            assign quo_src[s] = quo_ff[s-1];
            assign den_src[s] = den_ff[s-1];
            assign ovf_src[s] = ovf_ff[s-1];
         end

         always_comb begin
            logic [REM_WIDTH-1:0] r;
            logic [QUO_WIDTH-1:0] q;
            logic [MAG_WIDTH-1:0] d;
            int j;
            r = rem_src[s];
            q = quo_src[s];
            d = den_src[s];
            for (int t = 0; t < DIV_STEPS; t++) begin
               j = s * DIV_STEPS + t;
               if (j < QUO_WIDTH) begin
                  if (j != 0) r = r << 1;
                  if (r >= REM_WIDTH'(d)) begin
                     r = r - REM_WIDTH'(d);
                     q = q | (QUO_WIDTH'(1) << (QUO_WIDTH - 1 - j));
                  end
               end
            end
            rem_in[s] = r;
            quo_in[s] = q;
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in[s];
               quo_ff[s] <= quo_in[s];
               den_ff[s] <= den_src[s];
               ovf_ff[s] <= ovf_src[s];
            end
         end
      end
   endgenerate

   assign quo    = quo_ff[DIV_STAGES-1];
   assign rem_nz = rem_ff[DIV_STAGES-1] != '0;
   assign ovf    = ovf_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/swept_aabb_collision.sv
// Swept box collision test, one item per cycle while the output is not stalled.
// Pipeline: one input register, DIV_STAGES divider stages, one output register.
// Throughput: one item per cycle; a stalled result freezes the whole pipe.
// Reset: synchronous, active high; clears the valid bits only.
`default_nettype none
module swept_aabb_collision (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire swaabb_pkg::req_type req,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output swaabb_pkg::rsp_type      rsp
);
   import swaabb_pkg::*;

   // global advance: everything moves unless the output item is held
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // ---- stage 0: input register ----
   req_type in_ff;
   logic    in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) in_ff <= req;
   end

   // ---- per-axis distances and divider operands ----
   logic signed [DIST_WIDTH-1:0] de_x, dx_x, de_y, dx_y;
   logic signed [VEL_WIDTH-1:0]  v_x, v_y;
   logic [MAG_WIDTH-1:0] nde_x, ndx_x, nde_y, ndx_y, dv_x, dv_y;
   meta_type meta_in;

   always_comb begin
      logic signed [DIST_WIDTH-1:0] p1, s1, p2, s2;
      logic signed [DIST_WIDTH-1:0] a, b;

      // x axis
      v_x = VEL_WIDTH'(in_ff.first_vx) - VEL_WIDTH'(in_ff.second_vx);
      p1 = DIST_WIDTH'(in_ff.first_x);
      s1 = signed'(DIST_WIDTH'(in_ff.first_w));
      p2 = DIST_WIDTH'(in_ff.second_x);
      s2 = signed'(DIST_WIDTH'(in_ff.second_w));
      a = p2 - (p1 + s1);
      b = (p2 + s2) - p1;
      de_x = v_x[VEL_WIDTH-1] ? b : a;
      dx_x = v_x[VEL_WIDTH-1] ? a : b;

      // y axis
      v_y = VEL_WIDTH'(in_ff.first_vy) - VEL_WIDTH'(in_ff.second_vy);
      p1 = DIST_WIDTH'(in_ff.first_y);
      s1 = signed'(DIST_WIDTH'(in_ff.first_h));
      p2 = DIST_WIDTH'(in_ff.second_y);
      s2 = signed'(DIST_WIDTH'(in_ff.second_h));
      a = p2 - (p1 + s1);
      b = (p2 + s2) - p1;
      de_y = v_y[VEL_WIDTH-1] ? b : a;
      dx_y = v_y[VEL_WIDTH-1] ? a : b;

      // magnitudes for the unsigned dividers
      a = -de_x; nde_x = de_x[DIST_WIDTH-1] ? a[MAG_WIDTH-1:0] : de_x[MAG_WIDTH-1:0];
      a = -dx_x; ndx_x = dx_x[DIST_WIDTH-1] ? a[MAG_WIDTH-1:0] : dx_x[MAG_WIDTH-1:0];
      a = -de_y; nde_y = de_y[DIST_WIDTH-1] ? a[MAG_WIDTH-1:0] : de_y[MAG_WIDTH-1:0];
      a = -dx_y; ndx_y = dx_y[DIST_WIDTH-1] ? a[MAG_WIDTH-1:0] : dx_y[MAG_WIDTH-1:0];
      dv_x = v_x[VEL_WIDTH-1] ? MAG_WIDTH'(-v_x) : MAG_WIDTH'(v_x);
      dv_y = v_y[VEL_WIDTH-1] ? MAG_WIDTH'(-v_y) : MAG_WIDTH'(v_y);

      meta_in.valid      = in_valid_ff;
      meta_in.ax.v_zero  = v_x == '0;
      meta_in.ax.de_pos  = !de_x[DIST_WIDTH-1] && (de_x != '0);
      meta_in.ax.dx_pos  = !dx_x[DIST_WIDTH-1] && (dx_x != '0);
      meta_in.ax.ent_neg = de_x[DIST_WIDTH-1] ^ v_x[VEL_WIDTH-1];
      meta_in.ax.ex_neg  = dx_x[DIST_WIDTH-1] ^ v_x[VEL_WIDTH-1];
      meta_in.ay.v_zero  = v_y == '0;
      meta_in.ay.de_pos  = !de_y[DIST_WIDTH-1] && (de_y != '0);
      meta_in.ay.dx_pos  = !dx_y[DIST_WIDTH-1] && (dx_y != '0);
      meta_in.ay.ent_neg = de_y[DIST_WIDTH-1] ^ v_y[VEL_WIDTH-1];
      meta_in.ay.ex_neg  = dx_y[DIST_WIDTH-1] ^ v_y[VEL_WIDTH-1];
   end

   // ---- dividers: entry and exit time, each axis ----
   logic [QUO_WIDTH-1:0] q_ent_x, q_ex_x, q_ent_y, q_ex_y;
   logic rnz_ent_x, rnz_ex_x, rnz_ent_y, rnz_ex_y;
   logic ovf_ent_x, ovf_ex_x, ovf_ent_y, ovf_ex_y;

   swaabb_div u_div_ent_x (.clock, .en, .num(nde_x), .den(dv_x),
                           .quo(q_ent_x), .rem_nz(rnz_ent_x), .ovf(ovf_ent_x));
   swaabb_div u_div_ex_x  (.clock, .en, .num(ndx_x), .den(dv_x),
                           .quo(q_ex_x), .rem_nz(rnz_ex_x), .ovf(ovf_ex_x));
   swaabb_div u_div_ent_y (.clock, .en, .num(nde_y), .den(dv_y),
                           .quo(q_ent_y), .rem_nz(rnz_ent_y), .ovf(ovf_ent_y));
   swaabb_div u_div_ex_y  (.clock, .en, .num(ndx_y), .den(dv_y),
                           .quo(q_ex_y), .rem_nz(rnz_ex_y), .ovf(ovf_ex_y));

   // flags and valid travel alongside the divider stages
   meta_type meta_ff  [DIV_STAGES];
   meta_type meta_src [DIV_STAGES];

   genvar g;
   generate
      for (g = 0; g < DIV_STAGES; g++) begin : g_meta
         if (g == 0) begin : g_head
            assign meta_src[g] = meta_in;
         end else begin : g_tail
            assign meta_src[g] = meta_ff[g-1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               meta_ff[g].valid <= 1'b0;
            end else if (en) begin
               meta_ff[g].valid <= meta_src[g].valid;
            end
            if (en) begin
               meta_ff[g].ax <= meta_src[g].ax;
               meta_ff[g].ay <= meta_src[g].ay;
            end
         end
      end
   endgenerate

   // ---- final decision ----
   // Times are clamped to [-1, one+1]: the clamp keeps every test exact
   // since a hit needs both entry times at most one and at least one of them >= 0.
   meta_type m;
   assign m = meta_ff[DIV_STAGES-1];

   logic signed [TIME_WIDTH-1:0] t_ent_x, t_ex_x, t_ent_y, t_ex_y, t_entry, t_leave;
   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;
   side_type side;

   always_comb begin
      // zero relative velocity: infinities
      t_ent_x = m.ax.v_zero ? (m.ax.de_pos ? TIME_HI : TIME_LO)
                            : clamp_time(m.ax.ent_neg, ovf_ent_x, q_ent_x, rnz_ent_x);
      t_ex_x  = m.ax.v_zero ? (m.ax.dx_pos ? TIME_HI : TIME_LO)
                            : clamp_time(m.ax.ex_neg, ovf_ex_x, q_ex_x, rnz_ex_x);
      t_ent_y = m.ay.v_zero ? (m.ay.de_pos ? TIME_HI : TIME_LO)
                            : clamp_time(m.ay.ent_neg, ovf_ent_y, q_ent_y, rnz_ent_y);
      t_ex_y  = m.ay.v_zero ? (m.ay.dx_pos ? TIME_HI : TIME_LO)
                            : clamp_time(m.ay.ex_neg, ovf_ex_y, q_ex_y, rnz_ex_y);

      t_entry = (t_ent_x > t_ent_y) ? t_ent_x : t_ent_y;
      t_leave = (t_ex_x < t_ex_y) ? t_ex_x : t_ex_y;

      // tie goes to the y axis
      if (t_ent_x > t_ent_y) side = m.ax.de_pos ? SIDE_RIGHT : SIDE_LEFT;
      else                   side = m.ay.de_pos ? SIDE_DOWN : SIDE_UP;

      if ((t_entry > t_leave) || (t_ent_x < 0 && t_ent_y < 0) ||
          (t_ent_x > TIME_ONE) || (t_ent_y > TIME_ONE)) begin
         rsp_in.hit        = 1'b0;
         rsp_in.entry_time = '0;
         rsp_in.hit_side   = SIDE_UP;
      end else begin
         rsp_in.hit        = 1'b1;
         rsp_in.entry_time = t_entry[ETIME_WIDTH-1:0];
         rsp_in.hit_side   = side;
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/swaabb_chk.sv
`default_nettype none
module swaabb_chk (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire swaabb_pkg::rsp_type rsp
);
   import swaabb_pkg::*;

   // held item stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("held result changed");

   // a miss carries zero time and side
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.hit |-> rsp.entry_time == '0 && rsp.hit_side == SIDE_UP)
      else $error("miss with nonzero fields");

   // entry time never past one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.hit |-> rsp.entry_time <= ETIME_WIDTH'(TIME_ONE))
      else $error("entry time out of range");

   // a blocked output backs up into the input
   a_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input open while output blocked");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind swept_aabb_collision swaabb_chk u_swaabb_chk (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp(rsp)
);
`default_nettype wire
